// ===== src/cbm_pkg.sv =====
// package for the cartridge bank mapper: transaction types, codes and constants
package cbm_pkg;

  // board variant codes
  localparam logic [1:0] VARIANT_NONE   = 2'd0;
  localparam logic [1:0] VARIANT_CHR    = 2'd1;
  localparam logic [1:0] VARIANT_MIRROR = 2'd2;
  localparam logic [1:0] VARIANT_IRQ    = 2'd3;

  // configuration register indexes
  localparam logic [0:0] CFG_BOARD_VARIANT = 1'd0;
  localparam logic [0:0] CFG_PRG_TOTAL     = 1'd1;

  // request kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_CYCLES = 1'b1;

  // reset values of the configuration registers
  localparam logic [1:0] BOARD_VARIANT_RESET = VARIANT_IRQ;
  localparam logic [8:0] PRG_TOTAL_RESET     = 9'd8;

  // address decode masks and matches
  localparam logic [15:0] CHR_MASK         = 16'hE000;
  localparam logic [15:0] CHR_FIRST_MATCH  = 16'h8000;
  localparam logic [15:0] CHR_SECOND_MATCH = 16'hE000;
  localparam logic [15:0] MIR_MASK         = 16'hF001;
  localparam logic [15:0] MIR_SECOND_EVEN  = 16'h4000;
  localparam logic [15:0] MIR_SECOND_ODD   = 16'h4001;
  localparam logic [7:0]  MIR_SECOND_LOW   = 8'h25;
  localparam logic [15:0] MIR_FIRST_MATCH  = 16'h8001;
  localparam logic [15:0] IRQ_MASK         = 16'hE003;
  localparam logic [15:0] IRQ_FIRST_MATCH  = 16'hE000;
  localparam logic [15:0] IRQ_SECOND_MATCH = 16'hE001;
  localparam logic [15:0] IRQ_CTRL_MATCH   = 16'hE002;

  // control register enable bit and fixed main banks of the mirrored board
  localparam int unsigned IRQ_ENABLE_BIT = 1;
  localparam logic [6:0] MIR_MAIN_SMALL  = 7'd4;
  localparam logic [6:0] MIR_MAIN_LARGE  = 7'd7;
  localparam logic [6:0] MAIN_BANK_MAX   = 7'd127;

  // configuration port widths
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 9;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  cycle_count;
  } req_t;

  typedef struct packed {
    logic [3:0] low_window_bank;
    logic [6:0] main_window_bank;
    logic [3:0] pattern_bank;
    logic       mirror_vertical;
    logic       mirror_driven;
    logic       irq_line;
  } rsp_t;

endpackage

// ===== src/cartridge_bank_mapper_irq.sv =====
// Cartridge bank mapper with three board variants and a cycle-driven IRQ counter.
// Each request is a CPU write or an advance of the CPU time count; each returns a single response
// with the mapping and IRQ line as they stand after that request. Decode, the 16-bit
// counter add and the mapping sit in one combinational pass from the request to the
// response register, so one transaction is accepted every cycle while req_stall is low.
// A two-entry output stage (response register plus skid register) keeps requests flowing
// while a response is stalled; req_stall rises only when both are full. Configuration must
// be written through cfg_write/cfg_index/cfg_data only while idle; the block does not check.
module cartridge_bank_mapper_irq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [cbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  cbm_pkg::req_t                       req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output cbm_pkg::rsp_t                       rsp
);

  logic [1:0]    board_variant;
  logic [8:0]    prg_total;
  logic [7:0]    bank_first, bank_first_next;
  logic [7:0]    bank_second, bank_second_next;
  logic [7:0]    irq_control, irq_control_next;
  logic [15:0]   irq_counter, irq_counter_next;
  logic          irq_pending, irq_pending_next;
  logic [1:0]    variant;
  logic [9:0]    half_total;
  logic [6:0]    last_bank;
  logic          req_take;
  logic          skid_valid;
  cbm_pkg::rsp_t rsp_next;
  cbm_pkg::rsp_t skid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      board_variant <= cbm_pkg::BOARD_VARIANT_RESET;
      prg_total     <= cbm_pkg::PRG_TOTAL_RESET;
    end else if (cfg_write) begin
      if (cfg_index == cbm_pkg::CFG_BOARD_VARIANT) begin
        board_variant <= cfg_data[1:0];
      end else if (cfg_index == cbm_pkg::CFG_PRG_TOTAL) begin
        prg_total <= cfg_data;
      end
    end
  end

  // variant zero behaves as the irq board
  assign variant = (board_variant == cbm_pkg::VARIANT_NONE) ? cbm_pkg::VARIANT_IRQ
                                                            : board_variant;

  // write decode and counter update
  always_comb begin
    bank_first_next  = bank_first;
    bank_second_next = bank_second;
    irq_control_next = irq_control;
    irq_counter_next = irq_counter;
    irq_pending_next = irq_pending;
    if (req.kind == cbm_pkg::KIND_WRITE) begin
      unique case (variant)
        cbm_pkg::VARIANT_CHR: begin
          if ((req.address & cbm_pkg::CHR_MASK) == cbm_pkg::CHR_FIRST_MATCH) begin
            bank_first_next = req.write_data;
          end else if ((req.address & cbm_pkg::CHR_MASK) == cbm_pkg::CHR_SECOND_MATCH) begin
            bank_second_next = req.write_data;
          end
        end
        cbm_pkg::VARIANT_MIRROR: begin
          if (((req.address & cbm_pkg::MIR_MASK) == cbm_pkg::MIR_SECOND_EVEN ||
               (req.address & cbm_pkg::MIR_MASK) == cbm_pkg::MIR_SECOND_ODD) &&
              req.address[7:0] == cbm_pkg::MIR_SECOND_LOW) begin
            bank_second_next = req.write_data;
          end else if ((req.address & cbm_pkg::MIR_MASK) == cbm_pkg::MIR_FIRST_MATCH) begin
            bank_first_next = req.write_data;
          end
        end
        default: begin
          if ((req.address & cbm_pkg::IRQ_MASK) == cbm_pkg::IRQ_FIRST_MATCH) begin
            bank_first_next = req.write_data;
          end else if ((req.address & cbm_pkg::IRQ_MASK) == cbm_pkg::IRQ_SECOND_MATCH) begin
            bank_second_next = req.write_data;
          end else if ((req.address & cbm_pkg::IRQ_MASK) == cbm_pkg::IRQ_CTRL_MATCH) begin
            irq_control_next = req.write_data;
            if (!req.write_data[cbm_pkg::IRQ_ENABLE_BIT]) begin
              irq_counter_next = '0;
              irq_pending_next = 1'b0;
            end
          end
        end
      endcase
    end else if (variant == cbm_pkg::VARIANT_IRQ && irq_control[cbm_pkg::IRQ_ENABLE_BIT] &&
                 req.cycle_count != 8'd0) begin
      irq_counter_next = irq_counter + {8'd0, req.cycle_count};
      irq_pending_next = irq_counter_next[14] & irq_counter_next[13];
    end
  end

  // last 32k bank, saturated
  assign half_total = ({1'b0, prg_total} + 10'd1) >> 1;
  always_comb begin
    if (half_total == 10'd0) begin
      last_bank = 7'd0;
    end else if (half_total - 10'd1 > {3'd0, cbm_pkg::MAIN_BANK_MAX}) begin
      last_bank = cbm_pkg::MAIN_BANK_MAX;
    end else begin
      last_bank = 7'(half_total - 10'd1);
    end
  end

  // mapping from the updated state
  always_comb begin
    rsp_next.pattern_bank    = 4'd0;
    rsp_next.mirror_vertical = ~bank_second_next[3];
    rsp_next.mirror_driven   = 1'b1;
    rsp_next.irq_line        = irq_pending_next;
    unique case (variant)
      cbm_pkg::VARIANT_CHR: begin
        rsp_next.low_window_bank  = bank_second_next[3:0];
        rsp_next.main_window_bank = last_bank;
        rsp_next.pattern_bank     = bank_first_next[3:0];
        rsp_next.mirror_vertical  = 1'b0;
        rsp_next.mirror_driven    = 1'b0;
      end
      cbm_pkg::VARIANT_MIRROR: begin
        rsp_next.low_window_bank  = bank_first_next[4:1];
        rsp_next.main_window_bank = (prg_total[2:0] != 3'd0) ? cbm_pkg::MIR_MAIN_SMALL
                                                             : cbm_pkg::MIR_MAIN_LARGE;
      end
      default: begin
        rsp_next.low_window_bank  = bank_first_next[3:0];
        rsp_next.main_window_bank = last_bank;
      end
    endcase
  end

  assign req_stall = skid_valid;
  assign req_take  = req_valid && !skid_valid;

  // mapper state
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_first  <= '0;
      bank_second <= '0;
      irq_control <= '0;
      irq_counter <= '0;
      irq_pending <= 1'b0;
    end else if (req_take) begin
      bank_first  <= bank_first_next;
      bank_second <= bank_second_next;
      irq_control <= irq_control_next;
      irq_counter <= irq_counter_next;
      irq_pending <= irq_pending_next;
    end
  end

  // output stage: response register with a skid register behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!rsp_valid || !rsp_stall) begin
        if (skid_valid) begin
          rsp_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          rsp_valid <= req_take;
        end
      end else if (req_take) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // response payloads
  always_ff @(posedge clk) begin
    if (!rsp_valid || !rsp_stall) begin
      if (skid_valid) begin
        rsp <= skid;
      end else if (req_take) begin
        rsp <= rsp_next;
      end
    end else if (req_take) begin
      skid <= rsp_next;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the cartridge bank mapper with cycle-driven irq
`timescale 1ns / 100ps

module tb_top;

  localparam logic [15:0] IRQ_MATCH   = 16'h6000;
  localparam int          HOLD_CYCLES = 80;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          DRAIN_WAIT  = 8;
  localparam int          REPORT_MAX  = 40;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [cbm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [cbm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            req_valid = 1'b0;
  logic                            req_stall;
  cbm_pkg::req_t                   req = '0;
  logic                            rsp_valid;
  logic                            rsp_stall = 1'b0;
  cbm_pkg::rsp_t                   rsp;

  cartridge_bank_mapper_irq u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  // pending requests and expected mappings
  cbm_pkg::req_t request_q[$];
  cbm_pkg::rsp_t mapping_q[$];

  // mirror of the cartridge state and configuration
  logic [1:0]  cart_variant;
  logic [8:0]  cart_prg_total;
  logic [7:0]  bank_first;
  logic [7:0]  bank_second;
  logic [7:0]  irq_ctrl;
  logic [15:0] irq_count;
  logic        irq_high;

  // run control shared between the stimulus and the two bus processes
  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  bit rx_hold_arm = 1'b0;
  int tx_gap = 0;
  int rx_left = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int irq_rises = 0;
  int fail_count = 0;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // last 32k bank: half the 16k total rounded up, less one, saturated
  function automatic logic [6:0] last_main_bank(input logic [8:0] total);
    logic [9:0] half;
    half = ({1'b0, total} + 10'd1) >> 1;
    if (half == 10'd0) return 7'd0;
    half = half - 10'd1;
    return (half > {3'b000, cbm_pkg::MAIN_BANK_MAX}) ? cbm_pkg::MAIN_BANK_MAX : half[6:0];
  endfunction

  // apply one transaction to the mirror and queue the mapping it yields
  task automatic map_update(input cbm_pkg::req_t r);
    logic [1:0]    v;
    logic [15:0]   sel;
    cbm_pkg::rsp_t m;
    v = (cart_variant == cbm_pkg::VARIANT_NONE) ? cbm_pkg::VARIANT_IRQ : cart_variant;
    if (r.kind == cbm_pkg::KIND_WRITE) begin
      case (v)
        cbm_pkg::VARIANT_CHR: begin
          sel = r.address & cbm_pkg::CHR_MASK;
          if (sel == cbm_pkg::CHR_FIRST_MATCH) bank_first = r.write_data;
          else if (sel == cbm_pkg::CHR_SECOND_MATCH) bank_second = r.write_data;
        end
        cbm_pkg::VARIANT_MIRROR: begin
          sel = r.address & cbm_pkg::MIR_MASK;
          if ((sel == cbm_pkg::MIR_SECOND_EVEN || sel == cbm_pkg::MIR_SECOND_ODD) &&
              r.address[7:0] == cbm_pkg::MIR_SECOND_LOW) bank_second = r.write_data;
          else if (sel == cbm_pkg::MIR_FIRST_MATCH) bank_first = r.write_data;
        end
        default: begin
          sel = r.address & cbm_pkg::IRQ_MASK;
          if (sel == cbm_pkg::IRQ_FIRST_MATCH) begin
            bank_first = r.write_data;
          end else if (sel == cbm_pkg::IRQ_SECOND_MATCH) begin
            bank_second = r.write_data;
          end else if (sel == cbm_pkg::IRQ_CTRL_MATCH) begin
            irq_ctrl = r.write_data;
            if (!r.write_data[cbm_pkg::IRQ_ENABLE_BIT]) begin
              irq_count = 16'd0;
              irq_high = 1'b0;
            end
          end
        end
      endcase
    end else if (v == cbm_pkg::VARIANT_IRQ && irq_ctrl[cbm_pkg::IRQ_ENABLE_BIT] &&
                 r.cycle_count != 8'd0) begin
      // counter wraps at 16 bits, line follows bits 13 and 14
      irq_count = irq_count + {8'h00, r.cycle_count};
      if (!irq_high && (irq_count & IRQ_MATCH) == IRQ_MATCH) irq_rises++;
      irq_high = ((irq_count & IRQ_MATCH) == IRQ_MATCH);
    end

    m = '0;
    case (v)
      cbm_pkg::VARIANT_CHR: begin
        m.low_window_bank  = bank_second[3:0];
        m.main_window_bank = last_main_bank(cart_prg_total);
        m.pattern_bank     = bank_first[3:0];
      end
      cbm_pkg::VARIANT_MIRROR: begin
        m.low_window_bank  = bank_first[4:1];
        m.main_window_bank = (cart_prg_total[2:0] != 3'd0) ? cbm_pkg::MIR_MAIN_SMALL
                                                           : cbm_pkg::MIR_MAIN_LARGE;
        m.mirror_vertical  = ~bank_second[3];
        m.mirror_driven    = 1'b1;
      end
      default: begin
        m.low_window_bank  = bank_first[3:0];
        m.main_window_bank = last_main_bank(cart_prg_total);
        m.mirror_vertical  = ~bank_second[3];
        m.mirror_driven    = 1'b1;
      end
    endcase
    m.irq_line = irq_high;
    mapping_q.push_back(m);
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("%0t mismatch on %s: expected %0d actual %0d", $time, fname, want, got);
    end
  endtask

  // request driver: fed from the pending queue, payload held while stalled
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (req_valid && !req_stall) begin
        map_update(req);
        n_accepted++;
      end
      if (!req_valid || !req_stall) begin
        if (tx_gap != 0) begin
          tx_gap--;
          req_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          req <= request_q.pop_front();
          req_valid <= 1'b1;
          tx_gap = tx_gaps_on ? gap_len() : 0;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      rx_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (mapping_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected response: expected none actual %p", $time, rsp);
        end else begin
          cbm_pkg::rsp_t want;
          want = mapping_q.pop_front();
          check_field("low_window_bank", want.low_window_bank, rsp.low_window_bank);
          check_field("main_window_bank", want.main_window_bank, rsp.main_window_bank);
          check_field("pattern_bank", want.pattern_bank, rsp.pattern_bank);
          check_field("mirror_vertical", want.mirror_vertical, rsp.mirror_vertical);
          check_field("mirror_driven", want.mirror_driven, rsp.mirror_driven);
          check_field("irq_line", want.irq_line, rsp.irq_line);
        end
        n_checked++;
      end
      if (rx_hold_arm) begin
        rx_hold_arm = 1'b0;
        rx_left = HOLD_CYCLES;
      end
      if (rx_left != 0) begin
        rsp_stall <= 1'b1;
        rx_left--;
      end else begin
        rsp_stall <= 1'b0;
        rx_left = rx_stalls_on ? gap_len() : 0;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("[cartridge_bank_mapper_irq] ERROR");
    $finish;
  end

  task automatic queue_request(input logic k, input logic [15:0] a, input logic [7:0] d,
                               input logic [7:0] n);
    cbm_pkg::req_t r;
    r.kind = k;
    r.address = a;
    r.write_data = d;
    r.cycle_count = n;
    request_q.push_back(r);
  endtask

  // random transaction: counting mode is mostly long cycle runs
  function automatic cbm_pkg::req_t make_request(input bit counting);
    cbm_pkg::req_t r;
    int            pick;
    r.kind = 1'($urandom);
    r.address = 16'($urandom);
    r.write_data = 8'($urandom);
    r.cycle_count = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (counting) begin
      if (pick < 90) begin
        r.kind = cbm_pkg::KIND_CYCLES;
        r.cycle_count = 8'($urandom_range(200, 255));
      end else if (pick < 97) begin
        r.kind = cbm_pkg::KIND_WRITE;
        r.address = (r.address & ~cbm_pkg::IRQ_MASK) |
                    (pick[0] ? cbm_pkg::IRQ_FIRST_MATCH : cbm_pkg::IRQ_SECOND_MATCH);
      end else begin
        r.kind = cbm_pkg::KIND_CYCLES;
      end
    end else if (pick < 35) begin
      r.kind = cbm_pkg::KIND_CYCLES;
    end else if (pick < 80) begin
      r.kind = cbm_pkg::KIND_WRITE;
      case ($urandom_range(0, 6))
        0: r.address = (r.address & ~cbm_pkg::CHR_MASK) | cbm_pkg::CHR_FIRST_MATCH;
        1: r.address = (r.address & ~cbm_pkg::CHR_MASK) | cbm_pkg::CHR_SECOND_MATCH;
        2: r.address = {4'h4, r.address[11:8], cbm_pkg::MIR_SECOND_LOW};
        3: r.address = (r.address & ~cbm_pkg::MIR_MASK) | cbm_pkg::MIR_FIRST_MATCH;
        4: r.address = (r.address & ~cbm_pkg::IRQ_MASK) | cbm_pkg::IRQ_FIRST_MATCH;
        5: r.address = (r.address & ~cbm_pkg::IRQ_MASK) | cbm_pkg::IRQ_SECOND_MATCH;
        default: r.address = (r.address & ~cbm_pkg::IRQ_MASK) | cbm_pkg::IRQ_CTRL_MATCH;
      endcase
    end
    return r;
  endfunction

  task automatic queue_random(input int n, input bit counting);
    repeat (n) request_q.push_back(make_request(counting));
  endtask

  // returns at a falling edge once every transaction has been answered
  task automatic wait_idle();
    do @(negedge clk);
    while (request_q.size() != 0 || req_valid || mapping_q.size() != 0);
  endtask

  task automatic write_cfg(input logic [cbm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [cbm_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == cbm_pkg::CFG_BOARD_VARIANT) cart_variant = val[1:0];
    else if (idx == cbm_pkg::CFG_PRG_TOTAL) cart_prg_total = val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // stimulus sequence
  initial begin
    cart_variant = cbm_pkg::BOARD_VARIANT_RESET;
    cart_prg_total = cbm_pkg::PRG_TOTAL_RESET;
    bank_first = '0;
    bank_second = '0;
    irq_ctrl = '0;
    irq_count = '0;
    irq_high = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: irq board at reset configuration
    queue_request(cbm_pkg::KIND_CYCLES, 16'h0000, 8'h00, 8'd5);    // counter disabled
    queue_request(cbm_pkg::KIND_WRITE, cbm_pkg::IRQ_CTRL_MATCH, 8'h02, 8'h00);
    queue_request(cbm_pkg::KIND_CYCLES, 16'hFFFF, 8'hFF, 8'd0);    // zero cycles
    queue_request(cbm_pkg::KIND_CYCLES, 16'h0000, 8'h00, 8'd255);
    queue_request(cbm_pkg::KIND_WRITE, cbm_pkg::IRQ_FIRST_MATCH, 8'hFF, 8'h00);
    queue_request(cbm_pkg::KIND_WRITE, 16'hFFFD, 8'h08, 8'hFF);    // second bank, mirror bit set
    queue_request(cbm_pkg::KIND_WRITE, cbm_pkg::IRQ_SECOND_MATCH, 8'h00, 8'h00);
    queue_request(cbm_pkg::KIND_WRITE, 16'hE003, 8'hFF, 8'h00);    // undecoded
    queue_request(cbm_pkg::KIND_WRITE, 16'hFFFF, 8'hFF, 8'hFF);
    queue_request(cbm_pkg::KIND_WRITE, 16'h0000, 8'h00, 8'h00);
    queue_request(cbm_pkg::KIND_WRITE, 16'h6000, 8'hAA, 8'h00);
    queue_request(cbm_pkg::KIND_CYCLES, 16'h0000, 8'h00, 8'd1);
    queue_request(cbm_pkg::KIND_WRITE, 16'hFFFE, 8'hFD, 8'h00);    // disable clears counter
    queue_request(cbm_pkg::KIND_CYCLES, 16'h0000, 8'h00, 8'd200);
    queue_request(cbm_pkg::KIND_WRITE, cbm_pkg::IRQ_CTRL_MATCH, 8'hFF, 8'h00);
    queue_request(cbm_pkg::KIND_CYCLES, 16'hFFFF, 8'hFF, 8'd255);
    wait_idle();

    // chr board, rom of one 16k bank, no idling on either side
    write_cfg(cbm_pkg::CFG_BOARD_VARIANT, {7'd0, cbm_pkg::VARIANT_CHR});
    write_cfg(cbm_pkg::CFG_PRG_TOTAL, 9'd1);
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    queue_random(100, 1'b0);
    wait_idle();

    // mirrored-register board, both main bank choices
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    write_cfg(cbm_pkg::CFG_BOARD_VARIANT, {7'd0, cbm_pkg::VARIANT_MIRROR});
    write_cfg(cbm_pkg::CFG_PRG_TOTAL, 9'd8);
    queue_random(60, 1'b0);
    wait_idle();
    write_cfg(cbm_pkg::CFG_PRG_TOTAL, 9'd511);
    queue_random(40, 1'b0);
    wait_idle();

    // variant zero acts as the irq board; long receiver hold fills the block
    write_cfg(cbm_pkg::CFG_BOARD_VARIANT, {7'd0, cbm_pkg::VARIANT_NONE});
    write_cfg(cbm_pkg::CFG_PRG_TOTAL, 9'd256);
    tx_gaps_on = 1'b0;
    queue_random(100, 1'b0);
    rx_hold_arm = 1'b1;
    wait_idle();
    tx_gaps_on = 1'b1;

    // irq board: counter from zero through both irq windows and the wrap
    write_cfg(cbm_pkg::CFG_BOARD_VARIANT, {7'd0, cbm_pkg::VARIANT_IRQ});
    write_cfg(cbm_pkg::CFG_PRG_TOTAL, 9'd255);
    queue_request(cbm_pkg::KIND_WRITE, cbm_pkg::IRQ_CTRL_MATCH, 8'h00, 8'h00);
    queue_request(cbm_pkg::KIND_WRITE, cbm_pkg::IRQ_CTRL_MATCH, 8'h02, 8'h00);
    queue_random(320, 1'b1);
    wait_idle();

    // variant changes keep the irq state
    write_cfg(cbm_pkg::CFG_BOARD_VARIANT, {7'd0, cbm_pkg::VARIANT_CHR});
    write_cfg(cbm_pkg::CFG_PRG_TOTAL, 9'd0);
    queue_random(40, 1'b0);
    wait_idle();
    write_cfg(cbm_pkg::CFG_BOARD_VARIANT, {7'd0, cbm_pkg::VARIANT_MIRROR});
    write_cfg(cbm_pkg::CFG_PRG_TOTAL, 9'd2);
    queue_random(30, 1'b0);
    wait_idle();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mapping_q.size() != 0) begin
      fail_count++;
      $display("%0t %0d expected responses never arrived", $time, mapping_q.size());
    end

    $display("covered %0d requests on board variants 0 to 3, rom totals 0 to 511", n_accepted);
    $display("checked %0d responses, irq line rose %0d times", n_checked, irq_rises);
    if (fail_count == 0) begin
      $display("[cartridge_bank_mapper_irq] OK");
    end else begin
      $display("[cartridge_bank_mapper_irq] ERROR");
    end
    $finish;
  end

endmodule
